// ----- design/pmsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsa_pkg
// Shared types and constants of the padded message seed accumulator: input
// codes, padding constants, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pmsa_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned RotW  = 5;

  // Item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Padding constants.
  localparam logic [ByteW-1:0] PAD_BYTE      = 8'h80;
  localparam logic [3:0]       LEN_SLOT      = 4'd14;
  localparam logic [RotW-1:0]  LEN_WORDS     = 5'd2;

  typedef enum logic [1:0] {
    WSEL_LAST,
    WSEL_ZERO,
    WSEL_LEN_HI,
    WSEL_LEN_LO
  } wsel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_LO,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic  take_byte;
    logic  issue;
    wsel_e wsel;
    logic  finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pad_done;
    logic pipe_empty;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- design/pmsa_in_if.sv -----
// ----------------------------------------------------------------------------
// pmsa_in_if
// Input channel: one message byte or an end-of-message marker per transaction.
// ----------------------------------------------------------------------------
interface pmsa_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] message_byte;

  modport source (output valid, output kind, output message_byte, input ready);
  modport sink   (input valid, input kind, input message_byte, output ready);
endinterface

// ----- design/pmsa_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pmsa_cfg_if
// Configuration channel: writes the expected message length in bytes.
// ----------------------------------------------------------------------------
interface pmsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_bytes;

  modport source (output valid, output message_bytes, input ready);
  modport sink   (input valid, input message_bytes, output ready);
endinterface

// ----- design/pmsa_out_if.sv -----
// ----------------------------------------------------------------------------
// pmsa_out_if
// Result channel: the three seeds and the length flag of one message.
// ----------------------------------------------------------------------------
interface pmsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_seed;
  logic [31:0] y_seed;
  logic [31:0] z_seed;
  logic        length_error;

  modport source (output valid, output x_seed, output y_seed, output z_seed,
                  output length_error, input ready);
  modport sink   (input valid, input x_seed, input y_seed, input z_seed,
                  input length_error, output ready);
endinterface

// ----- design/pmsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmsa_ctrl
// Controller: takes bytes while idle and, on an end marker, walks the padding
// words, waits for the datapath to drain and hands the result over.
// ----------------------------------------------------------------------------
module pmsa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_kind_i,
  output logic                   in_ready_o,
  input  pmsa_pkg::ctrl_status_t status_i,
  output pmsa_pkg::ctrl_cmd_t    cmd_o
);
  import pmsa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_kind_i == KIND_END)) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (status_i.pad_done) begin
          state_d = ST_LEN_LO;
        end
      end
      ST_LEN_LO: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.pipe_empty && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.take_byte = 1'b0;
    cmd_o.issue     = 1'b0;
    cmd_o.wsel      = WSEL_ZERO;
    cmd_o.finish    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == KIND_END) begin
            cmd_o.issue = 1'b1;
            cmd_o.wsel  = WSEL_LAST;
          end else begin
            cmd_o.take_byte = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd_o.issue = 1'b1;
        cmd_o.wsel  = status_i.pad_done ? WSEL_LEN_HI : WSEL_ZERO;
      end
      ST_LEN_LO: begin
        cmd_o.issue = 1'b1;
        cmd_o.wsel  = WSEL_LEN_LO;
      end
      ST_FINISH: begin
        cmd_o.finish = status_i.pipe_empty && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- design/pmsa_datapath.sv -----
// ----------------------------------------------------------------------------
// pmsa_datapath
// Datapath: byte packing, padding word selection, a three-stage absorb
// pipeline (rotate, multiply, accumulate) and the result register.
// ----------------------------------------------------------------------------
module pmsa_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [31:0]            cfg_message_bytes_i,
  input  logic [7:0]             in_message_byte_i,
  input  pmsa_pkg::ctrl_cmd_t    cmd_i,
  output pmsa_pkg::ctrl_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            out_x_seed_o,
  output logic [31:0]            out_y_seed_o,
  output logic [31:0]            out_z_seed_o,
  output logic                   out_length_error_o
);
  import pmsa_pkg::*;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input logic [RotW-1:0]  k);
    logic [2*WordW-1:0] t;
    t = {v, v} << k;
    return t[2*WordW-1:WordW];
  endfunction

  // Message state.
  logic [31:0]      msg_bytes_q;
  logic [31:0]      bytes_rcvd_q, bytes_rcvd_d;
  logic [23:0]      partial_q, partial_d;
  logic [RotW-1:0]  word_idx_q, word_idx_d;
  logic [WordW-1:0] xor_acc_q, xor_acc_d;
  logic [WordW-1:0] prod_acc_q, prod_acc_d;
  logic [WordW-1:0] run_prod_q, run_prod_d;

  // Pipeline registers.
  logic             s1_valid_q, s2_valid_q;
  logic [WordW-1:0] s1_w_q, s1_r1_q, s1_r2_q;
  logic [WordW-1:0] s2_prod_q, s2_add_q;

  // Result register.
  logic             out_valid_q;
  logic [WordW-1:0] out_x_q, out_y_q, out_z_q;
  logic             out_err_q;

  logic [31:0]      bytes_inc;
  logic [31:0]      packed_word;
  logic             byte_absorb;
  logic             issue;
  logic [WordW-1:0] issue_word;
  logic [WordW-1:0] last_word;
  logic [RotW-1:0]  blk_words;
  logic [3:0]       zero_words;
  logic [RotW-1:0]  total_mod;
  logic [RotW-1:0]  rot1, rot2;

  // Only the padded word count modulo 32 matters for the rotations.
  assign blk_words  = msg_bytes_q[6:2] + 5'd1;
  assign zero_words = LEN_SLOT - blk_words[3:0];
  assign total_mod  = blk_words + {1'b0, zero_words} + LEN_WORDS;

  assign bytes_inc   = bytes_rcvd_q + 32'd1;
  assign packed_word = {partial_q, in_message_byte_i};
  assign byte_absorb = cmd_i.take_byte && (bytes_inc[1:0] == 2'd0);
  assign issue       = cmd_i.issue || byte_absorb;

  always_comb begin
    case (bytes_rcvd_q[1:0])
      2'd0:    last_word = {PAD_BYTE, 24'h0};
      2'd1:    last_word = {partial_q[7:0], PAD_BYTE, 16'h0};
      2'd2:    last_word = {partial_q[15:0], PAD_BYTE, 8'h0};
      default: last_word = {partial_q, PAD_BYTE};
    endcase
  end

  always_comb begin
    if (cmd_i.take_byte) begin
      issue_word = packed_word;
    end else begin
      unique case (cmd_i.wsel)
        WSEL_LAST:   issue_word = last_word;
        WSEL_ZERO:   issue_word = '0;
        WSEL_LEN_HI: issue_word = {29'h0, bytes_rcvd_q[31:29]};
        WSEL_LEN_LO: issue_word = {bytes_rcvd_q[28:0], 3'h0};
        default:     issue_word = '0;
      endcase
    end
  end

  assign rot1 = word_idx_q + 5'd1;
  assign rot2 = total_mod - word_idx_q;

  always_comb begin
    bytes_rcvd_d = bytes_rcvd_q;
    partial_d    = partial_q;
    word_idx_d   = word_idx_q;
    xor_acc_d    = xor_acc_q;
    prod_acc_d   = prod_acc_q;
    run_prod_d   = run_prod_q;
    if (cmd_i.take_byte) begin
      bytes_rcvd_d = bytes_inc;
      partial_d    = byte_absorb ? 24'h0 : packed_word[23:0];
    end
    if (issue) begin
      word_idx_d = word_idx_q + 5'd1;
    end
    if (s1_valid_q) begin
      xor_acc_d = xor_acc_q + (s1_w_q ^ s1_r1_q);
    end
    if (s2_valid_q) begin
      prod_acc_d = prod_acc_q + s2_prod_q;
      run_prod_d = run_prod_q * s2_add_q;
    end
    // The pipeline is empty when a message is finished.
    if (cmd_i.finish) begin
      bytes_rcvd_d = '0;
      partial_d    = '0;
      word_idx_d   = '0;
      xor_acc_d    = '0;
      prod_acc_d   = '0;
      run_prod_d   = 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_bytes_q  <= '0;
      bytes_rcvd_q <= '0;
      partial_q    <= '0;
      word_idx_q   <= '0;
      xor_acc_q    <= '0;
      prod_acc_q   <= '0;
      run_prod_q   <= 32'd1;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        msg_bytes_q <= cfg_message_bytes_i;
      end
      bytes_rcvd_q <= bytes_rcvd_d;
      partial_q    <= partial_d;
      word_idx_q   <= word_idx_d;
      xor_acc_q    <= xor_acc_d;
      prod_acc_q   <= prod_acc_d;
      run_prod_q   <= run_prod_d;
      s1_valid_q   <= issue;
      s2_valid_q   <= s1_valid_q;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_w_q  <= issue_word;
      s1_r1_q <= rotl(issue_word, rot1);
      s1_r2_q <= rotl(issue_word, rot2);
    end
    if (s1_valid_q) begin
      s2_prod_q <= s1_w_q * s1_r1_q;
      s2_add_q  <= (s1_w_q + s1_r2_q) | 32'd1;
    end
    if (cmd_i.finish) begin
      out_x_q   <= xor_acc_q;
      out_y_q   <= run_prod_q;
      out_z_q   <= prod_acc_q;
      out_err_q <= (bytes_rcvd_q != msg_bytes_q);
    end
  end

  assign status_o.pad_done   = (word_idx_q[3:0] == LEN_SLOT);
  assign status_o.pipe_empty = !s1_valid_q && !s2_valid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_x_seed_o       = out_x_q;
  assign out_y_seed_o       = out_y_q;
  assign out_z_seed_o       = out_z_q;
  assign out_length_error_o = out_err_q;

endmodule

// ----- design/padded_message_seed_accumulator.sv -----
// ----------------------------------------------------------------------------
// padded_message_seed_accumulator
// Packs message bytes into big-endian words, pads the message at its end and
// folds every word into three 32-bit seeds.
// ----------------------------------------------------------------------------
//   Channel | Direction | Payload                              | Transaction
//   in_i    | sink      | kind, message_byte                   | byte or end
//   cfg_i   | sink      | message_bytes                        | length write
//   out_o   | source    | x_seed, y_seed, z_seed, length_error | one per end
//
// Byte transactions stream back to back while the block is idle.
// An end transaction holds in_i.ready low while 3 to 18 padding words go
// one per cycle into the three-stage absorb pipeline, which then drains
// before the seeds are loaded into the result register.
// A result waiting on out_o stalls only the next end transaction.
// Reset clears all message state; the configured length resets to zero.
// ----------------------------------------------------------------------------
module padded_message_seed_accumulator (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmsa_in_if.sink    in_i,
  pmsa_cfg_if.sink   cfg_i,
  pmsa_out_if.source out_o
);
  import pmsa_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  pmsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pmsa_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_message_bytes_i (cfg_i.message_bytes),
    .in_message_byte_i   (in_i.message_byte),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .out_x_seed_o        (out_o.x_seed),
    .out_y_seed_o        (out_o.y_seed),
    .out_z_seed_o        (out_o.z_seed),
    .out_length_error_o  (out_o.length_error)
  );

endmodule

// ----- design/pmsa_checker.sv -----
// ----------------------------------------------------------------------------
// pmsa_checker
// Port-level checks of the seed accumulator, attached to the top level.
// ----------------------------------------------------------------------------
module pmsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_kind_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_seed_i,
  input logic [31:0] out_y_seed_i
);
  import pmsa_pkg::*;

  // An end transaction always starts the padding walk.
  a_end_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KIND_END)) |=> !in_ready_i)
    else $error("input still ready after an end transaction");

  // A result appears only while the input side is busy finishing a message.
  a_result_after_padding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised outside of message finishing");

  // A result is not raised right after an end transaction: the padding words come first.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KIND_END)) |=> !$rose(out_valid_i))
    else $error("result raised right after an end transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_x_seed_i) && $stable(out_y_seed_i)))
    else $error("stalled result changed");

endmodule

bind padded_message_seed_accumulator pmsa_checker u_pmsa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_kind_i    (in_i.kind),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_x_seed_i (out_o.x_seed),
  .out_y_seed_i (out_o.y_seed)
);
